@@ hdl/qmc_pkg.sv @@
package qmc_pkg;

  // Fixed-point format of every element.
  localparam int FRAC_BITS = 16;
  localparam int NS = 23;

  localparam logic [16:0] DET_TOL_RESET = 17'd64;
  localparam logic signed [20:0] ONE_Q = 21'sd1 <<< FRAC_BITS;
  localparam logic signed [39:0] ONE2_Q = 40'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [39:0] SAT_HI = 40'sd131071;
  localparam logic signed [39:0] SAT_LO = -40'sd131072;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_REJ = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  // Quaternion component that comes from the square root.
  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  typedef struct packed {
    logic [35:0] v;
    logic [35:0] r;
  } sq_t;

  typedef struct packed {
    logic [36:0] rem;
    logic [17:0] q;
  } dv_t;

  typedef struct packed {
    logic [17:0] val;
    logic        flag;
  } sat_t;

  // Contents of one pipeline stage; fields are filled as the item advances.
  typedef struct {
    logic               mode;
    logic signed [17:0] e    [9];
    logic signed [35:0] p    [9];
    logic signed [35:0] dp   [6];
    logic signed [39:0] ent  [9];
    logic signed [36:0] mn   [3];
    logic signed [54:0] dt   [3];
    logic signed [20:0] arg;
    logic signed [19:0] n    [3];
    logic               nneg [3];
    logic [18:0]        nmag [3];
    big_t               big;
    logic               degen;
    logic               rej;
    logic               sat;
    sq_t                sq;
    logic [18:0]        d;
    dv_t                dv   [3];
    logic               ovf  [3];
    logic [17:0]        res  [9];
    status_t            status;
  } st_t;

  // Clamp to the 18-bit signed range.
  function automatic sat_t sat18(input logic signed [39:0] v);
    sat_t o;
    if (v > SAT_HI) begin
      o.val  = SAT_HI[17:0];
      o.flag = 1'b1;
    end else if (v < SAT_LO) begin
      o.val  = SAT_LO[17:0];
      o.flag = 1'b1;
    end else begin
      o.val  = v[17:0];
      o.flag = 1'b0;
    end
    return o;
  endfunction

  // Drop FRAC_BITS fraction bits, rounding half away from zero.
  function automatic logic signed [39:0] rshift_frac(input logic signed [39:0] v);
    logic [39:0] m;
    m = v[39] ? 40'(-v) : 40'(v);
    m = (m + (40'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[39] ? -$signed(m) : $signed(m);
  endfunction

  // One digit of the bitwise integer square root.
  function automatic sq_t sqrt_step(input sq_t a, input logic [35:0] b);
    sq_t         o;
    logic [35:0] t;
    t = a.r + b;
    if (a.v >= t) begin
      o.v = a.v - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division.
  function automatic dv_t div_step(input dv_t a, input logic [36:0] dsh);
    dv_t o;
    if (a.rem >= dsh) begin
      o.rem = a.rem - dsh;
      o.q   = {a.q[16:0], 1'b1};
    end else begin
      o.rem = a.rem;
      o.q   = {a.q[16:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ hdl/qmc_intf.sv @@
interface qmc_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [17:0] elem_0;
  logic signed [17:0] elem_1;
  logic signed [17:0] elem_2;
  logic signed [17:0] elem_3;
  logic signed [17:0] elem_4;
  logic signed [17:0] elem_5;
  logic signed [17:0] elem_6;
  logic signed [17:0] elem_7;
  logic signed [17:0] elem_8;
  modport source (output valid, mode, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5,
                  elem_6, elem_7, elem_8, input ready);
  modport sink (input valid, mode, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5,
                elem_6, elem_7, elem_8, output ready);
endinterface

interface qmc_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] out_0;
  logic signed [17:0] out_1;
  logic signed [17:0] out_2;
  logic signed [17:0] out_3;
  logic signed [17:0] out_4;
  logic signed [17:0] out_5;
  logic signed [17:0] out_6;
  logic signed [17:0] out_7;
  logic signed [17:0] out_8;
  logic [1:0]         result_status;
  modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                  out_8, result_status, input ready);
  modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
                out_8, result_status, output ready);
endinterface

interface qmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] det_tolerance;
  modport source (output valid, det_tolerance, input ready);
  modport sink (input valid, det_tolerance, output ready);
endinterface

@@ hdl/qmc_pipe_ctl.sv @@
module qmc_pipe_ctl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic [qmc_pkg::NS-1:0] en
);
  import qmc_pkg::*;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;

  // A stage loads when it is empty or its content moves on; bubbles collapse.
  assign en[NS-1] = !v_r[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  // Valid bits travel with the data.
  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // Input is held off only when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &v_r)
    else $error("input blocked while a stage is empty");

  // Taking a result always frees the input side.
  a_take_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("result taken but input not ready");

  // Items in flight change only by accepted and delivered transactions.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
                      + int'($past(in_valid && in_ready))
                      - int'($past(out_valid && out_ready))))
    else $error("item lost or duplicated in pipeline");

endmodule

@@ hdl/quaternion_matrix_converter_unit.sv @@
// Quaternion / rotation matrix converter, signed 18-bit fixed point with 16
// fraction bits.
// in_chan carries one transaction per conversion: mode 0 turns x,y,z,w in
// elem_0..elem_3 into the nine row-major matrix entries; mode 1 turns a matrix
// into x,y,z,w on out_0..out_3 with out_4..out_8 zero. out_chan returns one
// result transaction per input with result_status 0 ok, 1 rejected (the
// determinant is farther from one than det_tolerance), 2 saturated.
// cfg_chan writes det_tolerance; it is always ready. The user must write
// det_tolerance only while idle; the block does not enforce this. The pipeline
// has 23 stages: four stages of products and sums, nine for the square root at
// two digits a stage, nine for the three parallel dividers at two quotient bits
// a stage, and a final packing stage. Throughput is one transaction per cycle
// while out_chan is ready. When out_chan stalls, the last stage holds its
// result and empty stages further up keep filling, so in_chan stays ready
// until every stage is occupied.
// Reset clears all stage valid bits and sets det_tolerance to 64.
module quaternion_matrix_converter_unit (
  input logic       clk,
  input logic       rst_n,
  qmc_in_if.sink    in_chan,
  qmc_out_if.source out_chan,
  qmc_cfg_if.sink   cfg_chan
);
  import qmc_pkg::*;

  logic [16:0]   det_tol_r;
  logic [NS-1:0] en;
  st_t           st_r   [NS];
  st_t           st_nxt [NS];

  // Configuration register.
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_tol_r <= DET_TOL_RESET;
    end else if (cfg_chan.valid) begin
      det_tol_r <= cfg_chan.det_tolerance;
    end
  end

  qmc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .en        (en)
  );

  // Input capture.
  always_comb begin
    st_nxt[0]      = st_r[0];
    st_nxt[0].mode = in_chan.mode;
    st_nxt[0].e[0] = in_chan.elem_0;
    st_nxt[0].e[1] = in_chan.elem_1;
    st_nxt[0].e[2] = in_chan.elem_2;
    st_nxt[0].e[3] = in_chan.elem_3;
    st_nxt[0].e[4] = in_chan.elem_4;
    st_nxt[0].e[5] = in_chan.elem_5;
    st_nxt[0].e[6] = in_chan.elem_6;
    st_nxt[0].e[7] = in_chan.elem_7;
    st_nxt[0].e[8] = in_chan.elem_8;
  end

  for (genvar k = 0; k < NS - 1; k++) begin : g_stage
    st_t o;

    if (k == 0) begin : g_front
      logic signed [19:0] tr;
      // Products for both modes, trace and branch selection.
      always_comb begin
        o = st_r[0];
        o.p[0]  = o.e[0] * o.e[0];
        o.p[1]  = o.e[1] * o.e[1];
        o.p[2]  = o.e[2] * o.e[2];
        o.p[3]  = o.e[0] * o.e[1];
        o.p[4]  = o.e[0] * o.e[2];
        o.p[5]  = o.e[1] * o.e[2];
        o.p[6]  = o.e[3] * o.e[0];
        o.p[7]  = o.e[3] * o.e[1];
        o.p[8]  = o.e[3] * o.e[2];
        o.dp[0] = o.e[4] * o.e[8];
        o.dp[1] = o.e[5] * o.e[7];
        o.dp[2] = o.e[3] * o.e[8];
        o.dp[3] = o.e[5] * o.e[6];
        o.dp[4] = o.e[3] * o.e[7];
        o.dp[5] = o.e[4] * o.e[6];
        tr = 20'(o.e[0]) + 20'(o.e[4]) + 20'(o.e[8]);
        priority if (tr > 20'sd0) begin
          o.big  = BIG_W;
          o.arg  = 21'(tr) + ONE_Q;
          o.n[0] = 20'(o.e[7]) - 20'(o.e[5]);
          o.n[1] = 20'(o.e[2]) - 20'(o.e[6]);
          o.n[2] = 20'(o.e[3]) - 20'(o.e[1]);
        end else if (o.e[0] > o.e[4] && o.e[0] > o.e[8]) begin
          o.big  = BIG_X;
          o.arg  = 21'(o.e[0]) - 21'(o.e[4]) - 21'(o.e[8]) + ONE_Q;
          o.n[0] = 20'(o.e[3]) + 20'(o.e[1]);
          o.n[1] = 20'(o.e[2]) + 20'(o.e[6]);
          o.n[2] = 20'(o.e[7]) - 20'(o.e[5]);
        end else if (o.e[4] > o.e[8]) begin
          o.big  = BIG_Y;
          o.arg  = 21'(o.e[4]) - 21'(o.e[0]) - 21'(o.e[8]) + ONE_Q;
          o.n[0] = 20'(o.e[3]) + 20'(o.e[1]);
          o.n[1] = 20'(o.e[7]) + 20'(o.e[5]);
          o.n[2] = 20'(o.e[2]) - 20'(o.e[6]);
        end else begin
          o.big  = BIG_Z;
          o.arg  = 21'(o.e[8]) - 21'(o.e[0]) - 21'(o.e[4]) + ONE_Q;
          o.n[0] = 20'(o.e[2]) + 20'(o.e[6]);
          o.n[1] = 20'(o.e[7]) + 20'(o.e[5]);
          o.n[2] = 20'(o.e[3]) - 20'(o.e[1]);
        end
        st_nxt[1] = o;
      end
    end else if (k == 1) begin : g_sums
      // Matrix entries at double precision, minors, square-root setup.
      always_comb begin
        o = st_r[1];
        o.ent[0] = ONE2_Q - ((40'(o.p[1]) + 40'(o.p[2])) <<< 1);
        o.ent[1] = (40'(o.p[3]) - 40'(o.p[8])) <<< 1;
        o.ent[2] = (40'(o.p[4]) + 40'(o.p[7])) <<< 1;
        o.ent[3] = (40'(o.p[3]) + 40'(o.p[8])) <<< 1;
        o.ent[4] = ONE2_Q - ((40'(o.p[0]) + 40'(o.p[2])) <<< 1);
        o.ent[5] = (40'(o.p[5]) - 40'(o.p[6])) <<< 1;
        o.ent[6] = (40'(o.p[4]) - 40'(o.p[7])) <<< 1;
        o.ent[7] = (40'(o.p[5]) + 40'(o.p[6])) <<< 1;
        o.ent[8] = ONE2_Q - ((40'(o.p[0]) + 40'(o.p[1])) <<< 1);
        o.mn[0]  = 37'(o.dp[0]) - 37'(o.dp[1]);
        o.mn[1]  = 37'(o.dp[2]) - 37'(o.dp[3]);
        o.mn[2]  = 37'(o.dp[4]) - 37'(o.dp[5]);
        o.degen  = (o.arg <= 21'sd0);
        o.sq.v   = 36'(o.arg[19:0]) << FRAC_BITS;
        o.sq.r   = '0;
        for (int i = 0; i < 3; i++) begin
          o.nneg[i] = o.n[i][19];
          o.nmag[i] = o.n[i][19] ? 19'(-o.n[i]) : 19'(o.n[i]);
        end
        st_nxt[2] = o;
      end
    end else if (k <= 10) begin : g_root
      localparam int Sh = 34 - 4 * (k - 2);
      sat_t               sv;
      logic signed [56:0] det;
      logic [56:0]        dmag;
      logic [24:0]        drnd;
      logic signed [25:0] detf;
      logic signed [25:0] det_err;
      logic [25:0]        adist;
      // Two square-root digits per stage; the first two stages also finish
      // the mode 0 entries and the determinant.
      always_comb begin
        o = st_r[k];
        sv      = '0;
        det     = '0;
        dmag    = '0;
        drnd    = '0;
        detf    = '0;
        det_err = '0;
        adist   = '0;
        o.sq = sqrt_step(sqrt_step(o.sq, 36'd1 << Sh), 36'd1 << (Sh - 2));
        if (k == 2) begin
          o.sat = 1'b0;
          for (int i = 0; i < 9; i++) begin
            sv       = sat18(rshift_frac(o.ent[i]));
            o.res[i] = sv.val;
            o.sat    = o.sat | sv.flag;
          end
          o.dt[0] = o.e[0] * o.mn[0];
          o.dt[1] = o.e[1] * o.mn[1];
          o.dt[2] = o.e[2] * o.mn[2];
        end
        if (k == 3) begin
          det     = 57'(o.dt[0]) - 57'(o.dt[1]) + 57'(o.dt[2]);
          dmag    = det[56] ? 57'(-det) : 57'(det);
          drnd    = 25'((dmag + (57'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS));
          detf    = det[56] ? -$signed({1'b0, drnd}) : $signed({1'b0, drnd});
          det_err = detf - 26'(ONE_Q);
          adist   = det_err[25] ? 26'(-det_err) : 26'(det_err);
          o.rej   = o.mode && (adist > 26'(det_tol_r));
        end
        st_nxt[k+1] = o;
      end
    end else if (k == 11) begin : g_div_init
      logic [17:0] r;
      // Divisor is twice the root; half the divisor is added for rounding.
      always_comb begin
        o   = st_r[11];
        r   = o.sq.r[17:0];
        o.d = {r, 1'b0};
        for (int i = 0; i < 3; i++) begin
          o.dv[i].rem = 37'({o.nmag[i], 16'b0}) + 37'(r);
          o.dv[i].q   = '0;
          o.ovf[i]    = o.dv[i].rem >= {o.d, 18'b0};
        end
        st_nxt[12] = o;
      end
    end else if (k <= 20) begin : g_div
      localparam int Hi = 17 - 2 * (k - 12);
      // Two quotient bits per stage for each of the three dividers.
      always_comb begin
        o = st_r[k];
        for (int i = 0; i < 3; i++) begin
          o.dv[i] = div_step(div_step(o.dv[i], 37'(o.d) << Hi), 37'(o.d) << (Hi - 1));
        end
        st_nxt[k+1] = o;
      end
    end else begin : g_pack
      logic signed [39:0] qv [3];
      logic [17:0]        qs [3];
      logic [17:0]        w;
      logic               sf;
      sat_t               sv;
      // Signs, saturation and placement of the root component.
      always_comb begin
        o  = st_r[k];
        sf = 1'b0;
        sv = '0;
        w  = 18'((19'(o.sq.r[17:0]) + 19'd1) >> 1);
        for (int i = 0; i < 3; i++) begin
          qv[i] = o.nneg[i] ? -$signed(40'(o.dv[i].q)) : $signed(40'(o.dv[i].q));
          if (o.ovf[i]) begin
            qv[i] = o.nneg[i] ? SAT_LO - 40'sd1 : SAT_HI + 40'sd1;
          end
          sv    = sat18(qv[i]);
          qs[i] = sv.val;
          sf    = sf | sv.flag;
        end
        if (o.mode) begin
          for (int i = 0; i < 9; i++) begin
            o.res[i] = '0;
          end
          if (o.rej) begin
            o.status = ST_REJ;
          end else if (o.degen) begin
            o.status = ST_SAT;
          end else begin
            unique case (o.big)
              BIG_X: begin
                o.res[0] = w;     o.res[1] = qs[0];
                o.res[2] = qs[1]; o.res[3] = qs[2];
              end
              BIG_Y: begin
                o.res[0] = qs[0]; o.res[1] = w;
                o.res[2] = qs[1]; o.res[3] = qs[2];
              end
              BIG_Z: begin
                o.res[0] = qs[0]; o.res[1] = qs[1];
                o.res[2] = w;     o.res[3] = qs[2];
              end
              BIG_W: begin
                o.res[0] = qs[0]; o.res[1] = qs[1];
                o.res[2] = qs[2]; o.res[3] = w;
              end
              default: begin
                o.res[0] = '0;
              end
            endcase
            o.status = sf ? ST_SAT : ST_OK;
          end
        end else begin
          o.status = o.sat ? ST_SAT : ST_OK;
        end
        st_nxt[k+1] = o;
      end
    end
  end

  // Stage registers advance under their own enable.
  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_chan.out_0         = st_r[NS-1].res[0];
  assign out_chan.out_1         = st_r[NS-1].res[1];
  assign out_chan.out_2         = st_r[NS-1].res[2];
  assign out_chan.out_3         = st_r[NS-1].res[3];
  assign out_chan.out_4         = st_r[NS-1].res[4];
  assign out_chan.out_5         = st_r[NS-1].res[5];
  assign out_chan.out_6         = st_r[NS-1].res[6];
  assign out_chan.out_7         = st_r[NS-1].res[7];
  assign out_chan.out_8         = st_r[NS-1].res[8];
  assign out_chan.result_status = st_r[NS-1].status;

endmodule

@@ sim/tb_quaternion_matrix_converter_unit.sv @@
module tb_quaternion_matrix_converter_unit;
  import qmc_pkg::*;

  typedef logic signed [17:0] elems_t [9];

  typedef struct {
    logic signed [17:0] v [9];
    status_t            st;
  } conversion_t;

  // Expected conversions and the arithmetic that produces them.
  class conversion_board;
    conversion_t   pending [$];
    longint        tolerance;
    int            errors;

    function new();
      tolerance = 64;
      errors    = 0;
    endfunction

    function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Drop s fraction bits, rounding half away from zero.
    function automatic longint round_shift(longint v, int s);
      longint m;
      m = (mag(v) + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function automatic longint round_div(longint num, longint den);
      longint q;
      q = (mag(num) + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function automatic conversion_t convert(logic m, elems_t e);
      conversion_t c;
      longint x [9];
      longint res [9];
      longint one, one2, det, det_err, tr, arg, r, n0, n1, n2;
      longint q [3];
      int big, k;
      bit clamp;
      one  = longint'(1) << FRAC_BITS;
      one2 = longint'(1) << (2 * FRAC_BITS);
      clamp = 0;
      for (int i = 0; i < 9; i++) begin
        x[i] = e[i];
        res[i] = 0;
      end
      if (!m) begin
        res[0] = one2 - 2 * (x[1] * x[1] + x[2] * x[2]);
        res[1] = 2 * (x[0] * x[1] - x[3] * x[2]);
        res[2] = 2 * (x[0] * x[2] + x[3] * x[1]);
        res[3] = 2 * (x[0] * x[1] + x[3] * x[2]);
        res[4] = one2 - 2 * (x[0] * x[0] + x[2] * x[2]);
        res[5] = 2 * (x[1] * x[2] - x[3] * x[0]);
        res[6] = 2 * (x[0] * x[2] - x[3] * x[1]);
        res[7] = 2 * (x[1] * x[2] + x[3] * x[0]);
        res[8] = one2 - 2 * (x[0] * x[0] + x[1] * x[1]);
        for (int i = 0; i < 9; i++) res[i] = round_shift(res[i], FRAC_BITS);
      end else begin
        det = x[0] * (x[4] * x[8] - x[5] * x[7])
            - x[1] * (x[3] * x[8] - x[5] * x[6])
            + x[2] * (x[3] * x[7] - x[4] * x[6]);
        det_err = mag(round_shift(det, 2 * FRAC_BITS) - one);
        if (det_err > tolerance) begin
          for (int i = 0; i < 9; i++) c.v[i] = '0;
          c.st = ST_REJ;
          return c;
        end
        tr = x[0] + x[4] + x[8];
        // Pick the component that comes out of the square root.
        if (tr > 0) begin
          big = BIG_W; arg = tr + one;
          n0 = x[7] - x[5]; n1 = x[2] - x[6]; n2 = x[3] - x[1];
        end else if (x[0] > x[4] && x[0] > x[8]) begin
          big = BIG_X; arg = x[0] - x[4] - x[8] + one;
          n0 = x[3] + x[1]; n1 = x[2] + x[6]; n2 = x[7] - x[5];
        end else if (x[4] > x[8]) begin
          big = BIG_Y; arg = x[4] - x[0] - x[8] + one;
          n0 = x[3] + x[1]; n1 = x[7] + x[5]; n2 = x[2] - x[6];
        end else begin
          big = BIG_Z; arg = x[8] - x[0] - x[4] + one;
          n0 = x[2] + x[6]; n1 = x[7] + x[5]; n2 = x[3] - x[1];
        end
        r = (arg > 0) ? int_sqrt(longint'(arg) << FRAC_BITS) : 0;
        if (r == 0) begin
          clamp = 1;
        end else begin
          q[0] = round_div(n0 * one, 2 * r);
          q[1] = round_div(n1 * one, 2 * r);
          q[2] = round_div(n2 * one, 2 * r);
          k = 0;
          for (int i = 0; i < 4; i++) begin
            if (i == big) begin
              res[i] = (r + 1) >>> 1;
            end else begin
              res[i] = q[k];
              k++;
            end
          end
        end
      end
      // Clamp to the 18-bit range and flag it.
      for (int i = 0; i < 9; i++) begin
        if (res[i] > 131071) begin
          res[i] = 131071; clamp = 1;
        end else if (res[i] < -131072) begin
          res[i] = -131072; clamp = 1;
        end
        c.v[i] = res[i][17:0];
      end
      c.st = clamp ? ST_SAT : ST_OK;
      return c;
    endfunction

    function void note_input(logic m, elems_t e);
      pending.push_back(convert(m, e));
    endfunction

    function void check_result(elems_t got, logic [1:0] st);
      conversion_t exp_c;
      if (pending.size() == 0) begin
        $error("result transaction with no conversion outstanding");
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got[i] !== exp_c.v[i]) begin
          $error("out_%0d: expected %0d, actual %0d", i, exp_c.v[i], got[i]);
          errors++;
        end
      end
      if (st !== exp_c.st) begin
        $error("result_status: expected %0d, actual %0d", exp_c.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  qmc_in_if  in_bus ();
  qmc_out_if out_bus ();
  qmc_cfg_if cfg_bus ();

  quaternion_matrix_converter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .cfg_chan(cfg_bus)
  );

  conversion_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        out_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watch both channels; note inputs, check results, and time out on silence.
  always @(posedge clk) begin
    elems_t e;
    elems_t o;
    bit moved;
    moved = 0;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      e = '{in_bus.elem_0, in_bus.elem_1, in_bus.elem_2, in_bus.elem_3, in_bus.elem_4,
            in_bus.elem_5, in_bus.elem_6, in_bus.elem_7, in_bus.elem_8};
      board.note_input(in_bus.mode, e);
      moved = 1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      o = '{out_bus.out_0, out_bus.out_1, out_bus.out_2, out_bus.out_3, out_bus.out_4,
            out_bus.out_5, out_bus.out_6, out_bus.out_7, out_bus.out_8};
      board.check_result(o, out_bus.result_status);
      moved = 1;
    end
    if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
      board.tolerance = cfg_bus.det_tolerance;
      moved = 1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one conversion and hold it until it is accepted.
  task automatic send_item(logic m, elems_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.valid  = 1'b1;
    in_bus.mode   = m;
    in_bus.elem_0 = e[0]; in_bus.elem_1 = e[1]; in_bus.elem_2 = e[2];
    in_bus.elem_3 = e[3]; in_bus.elem_4 = e[4]; in_bus.elem_5 = e[5];
    in_bus.elem_6 = e[6]; in_bus.elem_7 = e[7]; in_bus.elem_8 = e[8];
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [16:0] t);
    drain();
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.det_tolerance = t;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic signed [17:0] to_fixed(real r);
    real s;
    s = r * 65536.0;
    if (s > 131071.0) return 18'sd131071;
    if (s < -131072.0) return -18'sd131072;
    return 18'($rtoi(s + ((s >= 0.0) ? 0.5 : -0.5)));
  endfunction

  function automatic real rnd_unit();
    return real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0;
  endfunction

  // A rotation built from a random unit quaternion, as x,y,z,w or as a matrix.
  function automatic elems_t rotation(bit as_matrix);
    real qx, qy, qz, qw, n;
    elems_t e;
    qx = rnd_unit(); qy = rnd_unit(); qz = rnd_unit();
    qw = ($urandom_range(0, 1) == 1) ? rnd_unit() * 0.2 : rnd_unit();
    n = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
    if (n < 0.001) begin
      qw = 1.0; n = 1.0;
    end
    qx = qx / n; qy = qy / n; qz = qz / n; qw = qw / n;
    for (int i = 0; i < 9; i++) e[i] = 18'($urandom());
    if (!as_matrix) begin
      e[0] = to_fixed(qx); e[1] = to_fixed(qy); e[2] = to_fixed(qz); e[3] = to_fixed(qw);
    end else begin
      e[0] = to_fixed(1.0 - 2.0 * (qy * qy + qz * qz));
      e[1] = to_fixed(2.0 * (qx * qy - qw * qz));
      e[2] = to_fixed(2.0 * (qx * qz + qw * qy));
      e[3] = to_fixed(2.0 * (qx * qy + qw * qz));
      e[4] = to_fixed(1.0 - 2.0 * (qx * qx + qz * qz));
      e[5] = to_fixed(2.0 * (qy * qz - qw * qx));
      e[6] = to_fixed(2.0 * (qx * qz - qw * qy));
      e[7] = to_fixed(2.0 * (qy * qz + qw * qx));
      e[8] = to_fixed(1.0 - 2.0 * (qx * qx + qy * qy));
      // Occasionally nudge an entry so the determinant check is exercised.
      if ($urandom_range(0, 3) == 0)
        e[$urandom_range(0, 8)] += 18'(int'($urandom_range(0, 400)) - 200);
    end
    return e;
  endfunction

  task automatic send_random(int count);
    elems_t e;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_item(1'b0, rotation(1'b0));
      end else if (pick < 8) begin
        send_item(1'b1, rotation(1'b1));
      end else begin
        for (int i = 0; i < 9; i++) e[i] = 18'($urandom());
        send_item(1'($urandom()), e);
      end
    end
  endtask

  localparam logic signed [17:0] P1 = 18'sd65536;
  localparam logic signed [17:0] N1 = -18'sd65536;
  localparam logic signed [17:0] MX = 18'sd131071;
  localparam logic signed [17:0] MN = -18'sd131072;

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = 1'b0;
    in_bus.elem_0 = '0; in_bus.elem_1 = '0; in_bus.elem_2 = '0;
    in_bus.elem_3 = '0; in_bus.elem_4 = '0; in_bus.elem_5 = '0;
    in_bus.elem_6 = '0; in_bus.elem_7 = '0; in_bus.elem_8 = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.det_tolerance = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity and extreme quaternions, axis rotations, rejections.
    write_tolerance(17'd0);
    send_item(1'b0, '{0, 0, 0, P1, 0, 0, 0, 0, 0});
    send_item(1'b0, '{0, 0, 0, 0, MX, MN, MX, MN, MX});
    send_item(1'b0, '{MX, MX, MX, MX, 0, 0, 0, 0, 0});
    send_item(1'b0, '{MN, MN, MN, MN, MN, MN, MN, MN, MN});
    send_item(1'b0, '{MX, MN, MX, MN, 0, 0, 0, 0, 0});
    send_item(1'b0, '{P1, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item(1'b1, '{P1, 0, 0, 0, P1, 0, 0, 0, P1});
    send_item(1'b1, '{P1, 0, 0, 0, N1, 0, 0, 0, N1});
    send_item(1'b1, '{N1, 0, 0, 0, P1, 0, 0, 0, N1});
    send_item(1'b1, '{N1, 0, 0, 0, N1, 0, 0, 0, P1});
    send_item(1'b1, '{0, N1, 0, P1, 0, 0, 0, 0, P1});
    send_item(1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item(1'b1, '{MX, MX, MX, MX, MX, MX, MX, MX, MX});
    send_item(1'b1, '{MN, 0, 0, 0, MN, 0, 0, 0, P1 / 4});
    write_tolerance(17'd65536);
    send_item(1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item(1'b1, '{P1, 0, 0, 0, P1, 0, 0, 0, P1 + 100});
    send_item(1'b1, '{-18'sd32768, 0, 0, 0, -18'sd49152, 0, 0, 0, -18'sd49152});
    send_item(1'b1, '{0, MX, 0, MX, 0, 0, 0, 0, P1});
    send_item(1'b1, '{P1, MX, MN, 0, P1, 0, 0, 0, P1});

    // Sender idles lightly, receiver heavily.
    write_tolerance(17'd64);
    send_idle_pct = 9;
    recv_idle_pct = 51;
    send_random(170);

    // The other way round.
    write_tolerance(17'd65536);
    send_idle_pct = 51;
    recv_idle_pct = 9;
    send_random(170);

    // No idling; a long receiver hold-off fills the pipeline, then a pause.
    write_tolerance(17'($urandom_range(0, 2000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    send_random(80);
    drain();
    send_random(80);

    drain();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
